// ----- sv/rs_pkg.sv -----
package rs_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  function automatic int sum_w(input int sw, input int cw);
    return sw + cw;
  endfunction

  function automatic int prod_w(input int sw, input int cw);
    return 2 * (sw + cw);
  endfunction

  function automatic int sq_w(input int sw, input int cw);
    return 2 * sw + cw;
  endfunction

  function automatic int root_w(input int sw, input int cw);
    return (2 * sw + cw + ((2 * sw + cw) % 2)) / 2;
  endfunction

endpackage

// ----- sv/running_statistics.sv -----
// channel | valid        | ready        | payload
// sample  | sample_valid | sample_ready | sample, last
// result  | result_valid | result_ready | minimum, maximum, mean_value, std_dev,
//         |              |              | sample_count, overflow
//
// A sample without last is accepted in S_IDLE, then accumulated in S_ACC.
// A sample with last adds the report sequence on the shared adder: mean divide, then
// square, divide, subtract, divide, root; below two samples it ends after the mean.
// Reset clears the accumulators, state and result_valid; there is no clearing pass.
// The result waits in its output register while further samples are taken;
// a second report holds in its final step until the first is taken.
module running_statistics #(
  parameter int SAMPLE_BITS = rs_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = rs_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0] minimum,
  output logic signed [SAMPLE_BITS-1:0] maximum,
  output logic signed [SAMPLE_BITS-1:0] mean_value,
  output logic [SAMPLE_BITS-1:0]        std_dev,
  output logic [COUNT_BITS-1:0]         sample_count,
  output logic                          overflow
);

  localparam int SUMW = rs_pkg::sum_w(SAMPLE_BITS, COUNT_BITS);
  localparam int SQW  = rs_pkg::sq_w(SAMPLE_BITS, COUNT_BITS);

  logic                          upd;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] min_seen;
  logic signed [SAMPLE_BITS-1:0] max_seen;
  logic signed [SUMW-1:0]        running_sum;
  logic [SQW-1:0]                running_square_sum;
  logic [COUNT_BITS-1:0]         seen_count;
  logic                          dropped_flag;

  rs_accum #(.SW(SAMPLE_BITS), .CW(COUNT_BITS)) u_accum (
    .clk                (clk),
    .rst                (rst),
    .upd                (upd),
    .x_in               (x_q),
    .min_seen           (min_seen),
    .max_seen           (max_seen),
    .running_sum        (running_sum),
    .running_square_sum (running_square_sum),
    .seen_count         (seen_count),
    .dropped_flag       (dropped_flag)
  );

  rs_report #(.SW(SAMPLE_BITS), .CW(COUNT_BITS)) u_report (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .sample_ready       (sample_ready),
    .sample             (sample),
    .last               (last),
    .upd                (upd),
    .x_out              (x_q),
    .min_seen           (min_seen),
    .max_seen           (max_seen),
    .running_sum        (running_sum),
    .running_square_sum (running_square_sum),
    .seen_count         (seen_count),
    .dropped_flag       (dropped_flag),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .minimum            (minimum),
    .maximum            (maximum),
    .mean_value         (mean_value),
    .std_dev            (std_dev),
    .sample_count       (sample_count),
    .overflow           (overflow)
  );

endmodule

// ----- sv/rs_alu.sv -----
module rs_alu #(
  parameter int W = 64
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] result,
  output logic         carry
);

  logic [W:0] total;

  assign total  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign result = total[W-1:0];
  assign carry  = total[W];

endmodule

// ----- sv/rs_accum.sv -----
module rs_accum #(
  parameter int SW = rs_pkg::SAMPLE_BITS_DEF,
  parameter int CW = rs_pkg::COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    upd,
  input  logic signed [SW-1:0]                    x_in,
  output logic signed [SW-1:0]                    min_seen,
  output logic signed [SW-1:0]                    max_seen,
  output logic signed [rs_pkg::sum_w(SW, CW)-1:0] running_sum,
  output logic [rs_pkg::sq_w(SW, CW)-1:0]         running_square_sum,
  output logic [CW-1:0]                           seen_count,
  output logic                                    dropped_flag
);

  localparam int SUMW = rs_pkg::sum_w(SW, CW);
  localparam int SQW  = rs_pkg::sq_w(SW, CW);

  logic signed [2*SW-1:0] sq;
  logic                   full;

  assign sq   = x_in * x_in;
  assign full = &seen_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen           <= {1'b0, {(SW-1){1'b1}}};
      max_seen           <= {1'b1, {(SW-1){1'b0}}};
      running_sum        <= '0;
      running_square_sum <= '0;
      seen_count         <= '0;
      dropped_flag       <= 1'b0;
    end else if (upd) begin
      if (full) begin
        dropped_flag <= 1'b1;
      end else begin
        if (x_in < min_seen) min_seen <= x_in;
        if (x_in > max_seen) max_seen <= x_in;
        running_sum        <= running_sum + SUMW'($signed({{CW{x_in[SW-1]}}, x_in}));
        running_square_sum <= running_square_sum + {{(SQW-2*SW){1'b0}}, sq};
        seen_count         <= seen_count + CW'(1);
      end
    end
  end

endmodule

// ----- sv/rs_report.sv -----
module rs_report #(
  parameter int SW = rs_pkg::SAMPLE_BITS_DEF,
  parameter int CW = rs_pkg::COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    sample_valid,
  output logic                                    sample_ready,
  input  logic signed [SW-1:0]                    sample,
  input  logic                                    last,
  output logic                                    upd,
  output logic signed [SW-1:0]                    x_out,
  input  logic signed [SW-1:0]                    min_seen,
  input  logic signed [SW-1:0]                    max_seen,
  input  logic signed [rs_pkg::sum_w(SW, CW)-1:0] running_sum,
  input  logic [rs_pkg::sq_w(SW, CW)-1:0]         running_square_sum,
  input  logic [CW-1:0]                           seen_count,
  input  logic                                    dropped_flag,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic signed [SW-1:0]                    minimum,
  output logic signed [SW-1:0]                    maximum,
  output logic signed [SW-1:0]                    mean_value,
  output logic [SW-1:0]                           std_dev,
  output logic [CW-1:0]                           sample_count,
  output logic                                    overflow
);

  localparam int SUMW = rs_pkg::sum_w(SW, CW);
  localparam int PW   = rs_pkg::prod_w(SW, CW);
  localparam int SQW  = rs_pkg::sq_w(SW, CW);
  localparam int RW   = rs_pkg::root_w(SW, CW);
  localparam int SQE  = 2 * RW;
  localparam int REMW = RW + 2;
  localparam int CNTW = $clog2(PW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_MEAN = 4'd3;
  localparam logic [3:0] S_SQR  = 4'd4;
  localparam logic [3:0] S_DIVT = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_DIVV = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]      state;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   num;
  logic [PW-1:0]   acc;
  logic [REMW-1:0] rem;
  logic [RW-1:0]   root;
  logic [SW-1:0]   mean_q;
  logic            last_q;

  logic [SUMW-1:0] mag;
  logic            neg;
  logic [CW-1:0]   divisor;
  logic [PW-1:0]   alu_a;
  logic [PW-1:0]   alu_b;
  logic            alu_sub;
  logic [PW-1:0]   alu_y;
  logic            alu_c;
  logic [REMW-1:0] rem_next;
  logic [SUMW-1:0] quot;
  logic [SQW-1:0]  vq;
  logic [SW-1:0]   sd_sat;

  assign neg     = running_sum[SUMW-1];
  assign mag     = neg ? (SUMW'(0) - SUMW'(running_sum)) : SUMW'(running_sum);
  assign divisor = (state == S_DIVV) ? (seen_count - CW'(1)) : seen_count;
  assign sample_ready = (state == S_IDLE);
  assign upd     = (state == S_ACC);
  assign quot    = {num[SUMW-2:0], alu_c};
  assign vq      = {num[SQW-2:0], alu_c};
  assign sd_sat  = (|root[RW-1:SW]) ? {SW{1'b1}} : root[SW-1:0];

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state) inside
      S_MEAN, S_DIVT, S_DIVV: begin
        alu_a   = PW'({rem[CW-1:0], num[PW-1]});
        alu_b   = PW'(divisor);
        alu_sub = 1'b1;
      end
      S_SQR: begin
        alu_a = {acc[PW-2:0], 1'b0};
        alu_b = num[PW-1] ? PW'(mag) : '0;
      end
      S_DIFF: begin
        alu_a   = PW'(running_square_sum);
        alu_b   = PW'(num[SQW-1:0]);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = PW'({rem[REMW-3:0], num[PW-1:PW-2]});
        alu_b   = PW'({root, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign rem_next = alu_c ? alu_y[REMW-1:0] : alu_a[REMW-1:0];

  rs_alu #(.W(PW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_y),
    .carry  (alu_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != S_DONE)) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            x_out  <= sample;
            last_q <= last;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          state <= last_q ? S_PREP : S_IDLE;
        end
        S_PREP: begin
          num  <= PW'(mag) << (PW - SUMW);
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
          if (seen_count == '0) begin
            mean_q <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          rem <= rem_next;
          if (cnt == CNTW'(SUMW - 1)) begin
            mean_q <= neg ? SW'(SUMW'(0) - quot) : SW'(quot);
            cnt    <= '0;
            if (seen_count < CW'(2)) begin
              state <= S_DONE;
            end else begin
              num   <= PW'(mag) << (PW - SUMW);
              acc   <= '0;
              state <= S_SQR;
            end
          end else begin
            num <= {num[PW-2:0], alu_c};
            cnt <= cnt + CNTW'(1);
          end
        end
        S_SQR: begin
          acc <= alu_y;
          if (cnt == CNTW'(SUMW - 1)) begin
            num   <= alu_y;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVT;
          end else begin
            num <= num << 1;
            cnt <= cnt + CNTW'(1);
          end
        end
        S_DIVT: begin
          num <= {num[PW-2:0], alu_c};
          rem <= rem_next;
          if (cnt == CNTW'(PW - 1)) begin
            cnt   <= '0;
            state <= S_DIFF;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_DIFF: begin
          num   <= alu_c ? (PW'(alu_y[SQW-1:0]) << (PW - SQW)) : '0;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIVV;
        end
        S_DIVV: begin
          if (cnt == CNTW'(SQW - 1)) begin
            num   <= PW'(vq) << (PW - SQE);
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            num <= {num[PW-2:0], alu_c};
            rem <= rem_next;
            cnt <= cnt + CNTW'(1);
          end
        end
        S_SQRT: begin
          num  <= num << 2;
          rem  <= rem_next;
          root <= {root[RW-2:0], alu_c};
          if (cnt == CNTW'(RW - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            minimum      <= min_seen;
            maximum      <= max_seen;
            mean_value   <= mean_q;
            std_dev      <= sd_sat;
            sample_count <= seen_count;
            overflow     <= dropped_flag;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_sd_small: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_count < CW'(2)) |-> std_dev == '0)
    else $error("std_dev nonzero with fewer than two samples");

  a_mean_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_count == '0) |-> mean_value == '0)
    else $error("mean nonzero with no samples");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_count != '0) |-> minimum <= maximum)
    else $error("minimum above maximum");

  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the final step");

  a_root_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> cnt < CNTW'(RW))
    else $error("root step count out of range");
`endif

endmodule

// ----- tb/running_statistics_test.sv -----
`timescale 1ns / 100ps

module running_statistics_test;

  localparam int SW = rs_pkg::SAMPLE_BITS_DEF;
  localparam int CW = rs_pkg::COUNT_BITS_DEF;
  localparam int COUNT_LIMIT = (1 << CW) - 1;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint unsigned SD_MAX = (64'd1 << SW) - 1;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 want_report;
    int                   gap;
  } beat_t;

  typedef struct {
    logic signed [SW-1:0] minimum;
    logic signed [SW-1:0] maximum;
    logic signed [SW-1:0] mean_value;
    logic [SW-1:0]        std_dev;
    logic [CW-1:0]        sample_count;
    logic                 overflow;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic signed [SW-1:0] sample = '0;
  logic last = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [SW-1:0] minimum;
  logic signed [SW-1:0] maximum;
  logic signed [SW-1:0] mean_value;
  logic [SW-1:0] std_dev;
  logic [CW-1:0] sample_count;
  logic overflow;

  beat_t  pend_q[$];
  stats_t report_q[$];

  logic signed [SW-1:0] min_seen = SAMPLE_MAX;
  logic signed [SW-1:0] max_seen = SAMPLE_MIN;
  longint          sum_acc = 0;
  longint unsigned square_acc = 0;
  int              count_acc = 0;
  bit              dropped = 1'b0;

  int total_items = 0;
  int accepted_items = 0;
  int fail_count = 0;
  int stall_left = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;

  running_statistics dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .last(last),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .minimum(minimum),
    .maximum(maximum),
    .mean_value(mean_value),
    .std_dev(std_dev),
    .sample_count(sample_count),
    .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_sample(input logic signed [SW-1:0] value, input logic want_report);
    stats_t          r;
    longint          quot;
    longint unsigned sum_mag;
    longint unsigned sq_term;
    longint unsigned spread;
    longint unsigned root;
    if (count_acc >= COUNT_LIMIT) begin
      dropped = 1'b1;
    end else begin
      if (value < min_seen) min_seen = value;
      if (value > max_seen) max_seen = value;
      sum_acc += longint'(value);
      square_acc += longint'(value) * longint'(value);
      count_acc++;
    end
    if (want_report) begin
      r.minimum = min_seen;
      r.maximum = max_seen;
      r.mean_value = '0;
      r.std_dev = '0;
      r.sample_count = count_acc[CW-1:0];
      r.overflow = dropped;
      if (count_acc > 0) begin
        quot = sum_acc / longint'(count_acc);
        r.mean_value = quot[SW-1:0];
      end
      if (count_acc >= 2) begin
        sum_mag = (sum_acc < 0) ? longint'(-sum_acc) : longint'(sum_acc);
        sq_term = (sum_mag * sum_mag) / longint'(count_acc);
        spread = (square_acc > sq_term) ? square_acc - sq_term : 64'd0;
        root = int_sqrt(spread / longint'(count_acc - 1));
        r.std_dev = (root > SD_MAX) ? SD_MAX[SW-1:0] : root[SW-1:0];
      end
      report_q.push_back(r);
    end
  endtask

  task automatic compare_stat(input string field, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) quiet_tx = !quiet_tx;
    return quiet_tx ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    int small_v;
    small_v = $urandom_range(0, 1023) - 512;
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3: return small_v[SW-1:0];
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic add_item(input logic signed [SW-1:0] value, input logic want_report,
                          input int gap);
    beat_t b;
    b.value = value;
    b.want_report = want_report;
    b.gap = gap;
    pend_q.push_back(b);
    total_items++;
  endtask

  always @(posedge clk) begin : driver
    beat_t b;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!(sample_valid && !sample_ready)) begin
      if (sample_valid) begin
        accumulate_sample(sample, last);
        accepted_items++;
      end
      if (pend_q.size() == 0) begin
        sample_valid <= 1'b0;
      end else if (pend_q[0].gap != 0) begin
        b = pend_q.pop_front();
        b.gap--;
        pend_q.push_front(b);
        sample_valid <= 1'b0;
      end else begin
        b = pend_q.pop_front();
        sample_valid <= 1'b1;
        sample <= b.value;
        last <= b.want_report;
      end
    end
  end

  always @(posedge clk) begin : monitor
    stats_t e;
    if (rst) begin
      stall_left = 0;
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (report_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: count %0d, mean %0d", sample_count, mean_value);
        end else begin
          e = report_q.pop_front();
          compare_stat("minimum", e.minimum, minimum);
          compare_stat("maximum", e.maximum, maximum);
          compare_stat("mean_value", e.mean_value, mean_value);
          compare_stat("std_dev", e.std_dev, std_dev);
          compare_stat("sample_count", e.sample_count, sample_count);
          compare_stat("overflow", e.overflow, overflow);
        end
        stall_left = quiet_rx ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 7) == 0) quiet_rx = !quiet_rx;
      end else if (result_valid && stall_left > 0) begin
        stall_left--;
      end
      result_ready <= (stall_left == 0);
    end
  end

  initial begin
    add_item(SAMPLE_MAX, 1'b1, pick_gap());
    add_item(SAMPLE_MIN, 1'b1, pick_gap());
    add_item(SW'(0), 1'b0, pick_gap());
    add_item(SW'(1), 1'b1, pick_gap());
    add_item(SW'(-1), 1'b0, pick_gap());
    add_item(SW'(256), 1'b1, pick_gap());
    add_item(SW'(-256), 1'b0, pick_gap());
    add_item(16'h5555, 1'b0, pick_gap());
    add_item(16'haaaa, 1'b1, pick_gap());
    add_item(SAMPLE_MIN, 1'b0, 0);
    add_item(SAMPLE_MIN, 1'b0, 0);
    add_item(SAMPLE_MIN, 1'b1, 0);
    add_item(SAMPLE_MAX, 1'b0, pick_gap());
    add_item(SAMPLE_MAX, 1'b1, pick_gap());
    add_item(SW'(0), 1'b1, pick_gap());
    add_item(SW'(-2), 1'b1, pick_gap());
    for (int k = 0; k < 572; k++)
      add_item(pick_sample(), $urandom_range(0, 3) == 0, pick_gap());
    for (int k = 0; k < 12; k++)
      add_item(pick_sample(), (k < 2) || ($urandom_range(0, 1) == 1), pick_gap());

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (accepted_items != total_items) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && report_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #600_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rs_pkg.sv
sv/rs_alu.sv
sv/rs_accum.sv
sv/rs_report.sv
sv/running_statistics.sv
tb/running_statistics_test.sv
